// ===== design/wbxml_stream_decoder_assert.svh =====
// Assertion macros for the WBXML stream decoder.
`ifndef WBXML_STREAM_DECODER_ASSERT_SVH
`define WBXML_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define WSD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define WSD_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define WSD_ASSERT(lbl, prop, msg)
`define WSD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== design/wsd_pkg.sv =====
// Types, codes and defaults shared by the WBXML stream decoder.
package wsd_pkg;

   localparam int STACK_DEPTH_DEF = 32;

   localparam logic [4:0]  MAX_DEPTH_RST      = 5'd31;
   localparam logic [15:0] MAX_NODES_RST      = 16'd4096;
   localparam logic [19:0] MAX_TEXT_LEN_RST   = 20'd65536;
   localparam logic [23:0] MAX_OPAQUE_LEN_RST = 24'd1048576;
   localparam logic [19:0] MAX_TABLE_LEN_RST  = 20'd65536;

   localparam logic [2:0] REG_MAX_DEPTH      = 3'd0;
   localparam logic [2:0] REG_MAX_NODES      = 3'd1;
   localparam logic [2:0] REG_MAX_TEXT_LEN   = 3'd2;
   localparam logic [2:0] REG_MAX_OPAQUE_LEN = 3'd3;
   localparam logic [2:0] REG_MAX_TABLE_LEN  = 3'd4;

   localparam logic [3:0] EV_HEADER      = 4'd0;
   localparam logic [3:0] EV_TABLE_BYTE  = 4'd1;
   localparam logic [3:0] EV_TAG_OPEN    = 4'd2;
   localparam logic [3:0] EV_TAG_END     = 4'd3;
   localparam logic [3:0] EV_TEXT_BYTE   = 4'd4;
   localparam logic [3:0] EV_TEXT_END    = 4'd5;
   localparam logic [3:0] EV_TABLE_REF   = 4'd6;
   localparam logic [3:0] EV_OPQ_START   = 4'd7;
   localparam logic [3:0] EV_OPQ_BYTE    = 4'd8;
   localparam logic [3:0] EV_ERROR       = 4'd10;

   localparam logic [3:0] ERR_NONE     = 4'd0;
   localparam logic [3:0] ERR_TRUNC    = 4'd1;
   localparam logic [3:0] ERR_BAD_TAG  = 4'd2;
   localparam logic [3:0] ERR_NUMBER   = 4'd3;
   localparam logic [3:0] ERR_DEPTH    = 4'd4;
   localparam logic [3:0] ERR_NODES    = 4'd5;
   localparam logic [3:0] ERR_TEXT     = 4'd6;
   localparam logic [3:0] ERR_OPAQUE   = 4'd7;
   localparam logic [3:0] ERR_TABLE    = 4'd8;
   localparam logic [3:0] ERR_OFFSET   = 4'd9;
   localparam logic [3:0] ERR_TRAILING = 4'd10;

   localparam logic [1:0] HF_VERSION   = 2'd0;
   localparam logic [1:0] HF_TABLE_LEN = 2'd3;

   localparam logic [1:0] DOC_OPEN     = 2'd0;
   localparam logic [1:0] DOC_ACCEPTED = 2'd1;
   localparam logic [1:0] DOC_REJECTED = 2'd2;

   localparam logic [7:0] TOK_SWITCH_PAGE = 8'h00;
   localparam logic [7:0] TOK_END         = 8'h01;
   localparam logic [7:0] TOK_STR_I       = 8'h03;
   localparam logic [7:0] TOK_STR_T       = 8'h83;
   localparam logic [7:0] TOK_OPAQUE      = 8'hC3;
   localparam logic [5:0] TOK_FIRST_TAG   = 6'd5;

   typedef enum logic [10:0] {
      PH_VERSION = 11'b000_0000_0001,
      PH_HEADNUM = 11'b000_0000_0010,
      PH_TABLE   = 11'b000_0000_0100,
      PH_ROOT    = 11'b000_0000_1000,
      PH_PAGE    = 11'b000_0001_0000,
      PH_CONTENT = 11'b000_0010_0000,
      PH_TEXT    = 11'b000_0100_0000,
      PH_REFNUM  = 11'b000_1000_0000,
      PH_OPQNUM  = 11'b001_0000_0000,
      PH_OPQDATA = 11'b010_0000_0000,
      PH_DONE    = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [3:0]  event_kind;
      logic [31:0] value;
      logic [1:0]  header_field;
      logic [7:0]  page_id;
      logic [5:0]  token;
      logic        with_body;
      logic [4:0]  depth;
      logic [3:0]  error_code;
      logic [1:0]  document_end;
   } rsp_type;

endpackage

// ===== design/wbxml_stream_decoder.sv =====
// Top level of the WBXML stream decoder: header parser, tokenizer and limit checks.
//
// Usage: feed one document byte per request on req_data_byte, with req_last high on
// the final byte of each document. Each request yields zero or one event on the rsp
// channel: header values, table bytes, tag open/end, text bytes and text end, table
// references, opaque start and bytes, or a numbered error.
// Each event is registered: it appears on rsp in the cycle after its request is accepted.
// Throughput: one request per cycle, sustained while rsp is drained; the tokenizer updates small
// registers and one text-length stack entry per byte, and a tag end reloads the
// enclosing level's text length from the stack RAM in the following cycle.
// Stall: the result register holds an event until rsp_ready; req_ready stays high
// while the result register is empty or being drained in the same cycle.
// Reset: all parsing state returns to the start of a document and the limit
// registers take their defaults. The text-length stack needs no clearing pass.
// After an error, requests are consumed silently up to the next final byte.
// Users must write limits over the APB port only while the decoder is idle; the block does not enforce it.
module wbxml_stream_decoder
   import wsd_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_event_kind,
   output logic [31:0] rsp_value,
   output logic [1:0]  rsp_header_field,
   output logic [7:0]  rsp_page_id,
   output logic [5:0]  rsp_token,
   output logic        rsp_with_body,
   output logic [4:0]  rsp_depth,
   output logic [3:0]  rsp_error_code,
   output logic [1:0]  rsp_document_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [8:0] StackDepthW = 9'(STACK_DEPTH);

   `include "wbxml_stream_decoder_assert.svh"

   logic [4:0]  max_depth_ff;
   logic [15:0] max_nodes_ff;
   logic [19:0] max_text_len_ff;
   logic [23:0] max_opaque_len_ff;
   logic [19:0] max_table_len_ff;

   phase_type   phase_ff, phase_in;
   logic [31:0] number_accum_ff, number_accum_in;
   logic [2:0]  number_bytes_ff, number_bytes_in;
   logic [1:0]  header_index_ff, header_index_in;
   logic [19:0] table_size_ff, table_size_in;
   logic [23:0] bytes_remaining_ff, bytes_remaining_in;
   logic [5:0]  open_depth_ff, open_depth_in;
   logic [16:0] nodes_seen_ff, nodes_seen_in;
   logic [7:0]  page_now_ff, page_now_in;
   logic        root_closed_ff, root_closed_in;
   logic        error_latched_ff, error_latched_in;
   logic [19:0] text_now_ff, text_now_in;
   logic        text_pend_ff, text_pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   rsp_type     ev;
   logic        have_ev;
   logic [3:0]  err;
   logic        accept;
   logic        do_tag;
   logic        clear_doc;
   logic [7:0]  b;
   logic [31:0] num_new;
   logic [2:0]  num_cnt;
   logic        num_ovf;
   logic [5:0]  tag_d;
   logic [8:0]  tag_d_ext;
   logic        tag_depth_err;
   logic        tag_bad;
   logic [16:0] nodes_inc;
   logic [5:0]  depth_dec;
   logic [8:0]  depth_dec_ext;
   logic [8:0]  depth_up_ext;
   logic [20:0] text_inc;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [19:0]   wr_data, rd_data;

   wsd_ram #(
      .WIDTH(20),
      .DEPTH(STACK_DEPTH)
   ) u_text_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign pready    = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_depth_ff      <= MAX_DEPTH_RST;
         max_nodes_ff      <= MAX_NODES_RST;
         max_text_len_ff   <= MAX_TEXT_LEN_RST;
         max_opaque_len_ff <= MAX_OPAQUE_LEN_RST;
         max_table_len_ff  <= MAX_TABLE_LEN_RST;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[4:2])
            REG_MAX_DEPTH:      max_depth_ff      <= pwdata[4:0];
            REG_MAX_NODES:      max_nodes_ff      <= pwdata[15:0];
            REG_MAX_TEXT_LEN:   max_text_len_ff   <= pwdata[19:0];
            REG_MAX_OPAQUE_LEN: max_opaque_len_ff <= pwdata[23:0];
            REG_MAX_TABLE_LEN:  max_table_len_ff  <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_MAX_DEPTH:      prdata = {27'd0, max_depth_ff};
         REG_MAX_NODES:      prdata = {16'd0, max_nodes_ff};
         REG_MAX_TEXT_LEN:   prdata = {12'd0, max_text_len_ff};
         REG_MAX_OPAQUE_LEN: prdata = {8'd0, max_opaque_len_ff};
         REG_MAX_TABLE_LEN:  prdata = {12'd0, max_table_len_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // shared helpers for numbers, tags, depth, node count and text length
   always_comb begin
      num_ovf  = (number_accum_ff[31:25] != 7'd0);
      num_new  = {number_accum_ff[24:0], b[6:0]};
      num_cnt  = number_bytes_ff + 3'd1;
      if (!num_ovf && b[7] && num_cnt >= 3'd5) begin
         num_ovf = 1'b1;
      end
      tag_d         = (phase_ff == PH_ROOT) ? 6'd0 : open_depth_ff;
      tag_d_ext     = {3'd0, tag_d};
      tag_depth_err = (tag_d > {1'b0, max_depth_ff}) || (tag_d_ext >= StackDepthW);
      tag_bad       = b[7] || (b[5:0] < TOK_FIRST_TAG);
      nodes_inc     = nodes_seen_ff + 17'd1;
      depth_dec     = open_depth_ff - 6'd1;
      depth_dec_ext = {3'd0, depth_dec};
      depth_up_ext  = depth_dec_ext - 9'd1;
      text_inc      = {1'b0, text_now_ff} + 21'd1;
   end

   always_comb begin
      phase_in           = phase_ff;
      number_accum_in    = number_accum_ff;
      number_bytes_in    = number_bytes_ff;
      header_index_in    = header_index_ff;
      table_size_in      = table_size_ff;
      bytes_remaining_in = bytes_remaining_ff;
      open_depth_in      = open_depth_ff;
      nodes_seen_in      = nodes_seen_ff;
      page_now_in        = page_now_ff;
      root_closed_in     = root_closed_ff;
      error_latched_in   = error_latched_ff;
      text_now_in        = text_pend_ff ? rd_data : text_now_ff;
      text_pend_in       = 1'b0;
      ev                 = '0;
      have_ev            = 1'b0;
      err                = ERR_NONE;
      do_tag             = 1'b0;
      clear_doc          = 1'b0;
      wr_en              = 1'b0;
      wr_addr            = tag_d_ext[AW-1:0];
      wr_data            = 20'd0;
      rd_en              = 1'b0;
      rd_addr            = depth_up_ext[AW-1:0];

      if (accept) begin
         if (error_latched_ff) begin
            clear_doc = req_last;
         end else begin
            unique case (phase_ff) inside
               PH_VERSION: begin
                  ev.event_kind   = EV_HEADER;
                  ev.value        = {24'd0, b};
                  ev.header_field = HF_VERSION;
                  have_ev         = 1'b1;
                  phase_in        = PH_HEADNUM;
                  header_index_in = 2'd1;
                  number_accum_in = 32'd0;
                  number_bytes_in = 3'd0;
               end
               PH_HEADNUM, PH_REFNUM, PH_OPQNUM: begin
                  if (num_ovf) begin
                     err = ERR_NUMBER;
                  end else if (b[7]) begin
                     number_accum_in = num_new;
                     number_bytes_in = num_cnt;
                  end else begin
                     number_accum_in = 32'd0;
                     number_bytes_in = 3'd0;
                     if (phase_ff == PH_HEADNUM) begin
                        if (header_index_ff == 2'd3) begin
                           if (num_new > {12'd0, max_table_len_ff}) begin
                              err = ERR_TABLE;
                           end else begin
                              ev.event_kind      = EV_HEADER;
                              ev.value           = num_new;
                              ev.header_field    = HF_TABLE_LEN;
                              have_ev            = 1'b1;
                              table_size_in      = num_new[19:0];
                              bytes_remaining_in = num_new[23:0];
                              phase_in = (num_new != 32'd0) ? PH_TABLE : PH_ROOT;
                           end
                        end else begin
                           ev.event_kind   = EV_HEADER;
                           ev.value        = num_new;
                           ev.header_field = header_index_ff;
                           have_ev         = 1'b1;
                           header_index_in = header_index_ff + 2'd1;
                        end
                     end else if (phase_ff == PH_REFNUM) begin
                        if (num_new >= {12'd0, table_size_ff}) begin
                           err = ERR_OFFSET;
                        end else begin
                           ev.event_kind = EV_TABLE_REF;
                           ev.value      = num_new;
                           have_ev       = 1'b1;
                           phase_in      = PH_CONTENT;
                        end
                     end else begin
                        if (num_new > {8'd0, max_opaque_len_ff}) begin
                           err = ERR_OPAQUE;
                        end else begin
                           ev.event_kind      = EV_OPQ_START;
                           ev.value           = num_new;
                           have_ev            = 1'b1;
                           bytes_remaining_in = num_new[23:0];
                           phase_in = (num_new != 32'd0) ? PH_OPQDATA : PH_CONTENT;
                        end
                     end
                  end
               end
               PH_TABLE, PH_OPQDATA: begin
                  ev.event_kind      = (phase_ff == PH_TABLE) ? EV_TABLE_BYTE : EV_OPQ_BYTE;
                  ev.value           = {24'd0, b};
                  have_ev            = 1'b1;
                  bytes_remaining_in = bytes_remaining_ff - 24'd1;
                  if (bytes_remaining_ff == 24'd1) begin
                     phase_in = (phase_ff == PH_TABLE) ? PH_ROOT : PH_CONTENT;
                  end
               end
               PH_ROOT: begin
                  if (b == TOK_SWITCH_PAGE) begin
                     phase_in = PH_PAGE;
                  end else begin
                     do_tag = 1'b1;
                  end
               end
               PH_PAGE: begin
                  page_now_in = b;
                  phase_in    = (open_depth_ff != 6'd0) ? PH_CONTENT : PH_ROOT;
               end
               PH_CONTENT: begin
                  case (b)
                     TOK_SWITCH_PAGE: phase_in = PH_PAGE;
                     TOK_END: begin
                        open_depth_in = depth_dec;
                        ev.event_kind = EV_TAG_END;
                        ev.depth      = depth_dec[4:0];
                        have_ev       = 1'b1;
                        if (depth_dec == 6'd0) begin
                           root_closed_in = 1'b1;
                           phase_in       = PH_DONE;
                        end else begin
                           rd_en        = 1'b1;
                           text_pend_in = 1'b1;
                        end
                     end
                     TOK_STR_I:  phase_in = PH_TEXT;
                     TOK_STR_T:  phase_in = PH_REFNUM;
                     TOK_OPAQUE: phase_in = PH_OPQNUM;
                     default:    do_tag   = 1'b1;
                  endcase
               end
               PH_TEXT: begin
                  if (b == 8'd0) begin
                     ev.event_kind = EV_TEXT_END;
                     ev.value      = {12'd0, text_now_ff};
                     have_ev       = 1'b1;
                     phase_in      = PH_CONTENT;
                  end else if (text_inc > {1'b0, max_text_len_ff}) begin
                     err = ERR_TEXT;
                  end else begin
                     text_now_in   = text_inc[19:0];
                     wr_en         = 1'b1;
                     wr_addr       = depth_dec_ext[AW-1:0];
                     wr_data       = text_inc[19:0];
                     ev.event_kind = EV_TEXT_BYTE;
                     ev.value      = {24'd0, b};
                     have_ev       = 1'b1;
                  end
               end
               PH_DONE: err = ERR_TRAILING;
               default: err = ERR_TRAILING;
            endcase

            if (do_tag) begin
               if (tag_depth_err) begin
                  err = ERR_DEPTH;
               end else if (tag_bad) begin
                  err = ERR_BAD_TAG;
               end else begin
                  nodes_seen_in = nodes_inc;
                  if (nodes_inc > {1'b0, max_nodes_ff}) begin
                     err = ERR_NODES;
                  end else begin
                     ev.event_kind = EV_TAG_OPEN;
                     ev.page_id    = page_now_ff;
                     ev.token      = b[5:0];
                     ev.with_body  = b[6];
                     ev.depth      = tag_d[4:0];
                     have_ev       = 1'b1;
                     if (b[6]) begin
                        wr_en         = 1'b1;
                        wr_data       = 20'd0;
                        text_now_in   = 20'd0;
                        text_pend_in  = 1'b0;
                        open_depth_in = tag_d + 6'd1;
                        phase_in      = PH_CONTENT;
                     end else if (tag_d == 6'd0) begin
                        root_closed_in = 1'b1;
                        phase_in       = PH_DONE;
                     end
                  end
               end
            end

            if (err == ERR_NONE && req_last) begin
               if (phase_in == PH_DONE && have_ev) begin
                  ev.document_end = DOC_ACCEPTED;
               end else begin
                  err = ERR_TRUNC;
               end
            end
            if (err != ERR_NONE) begin
               ev               = '0;
               ev.event_kind    = EV_ERROR;
               ev.error_code    = err;
               ev.document_end  = DOC_REJECTED;
               have_ev          = 1'b1;
               error_latched_in = 1'b1;
            end
            clear_doc = req_last;
         end
      end

      if (clear_doc) begin
         phase_in           = PH_VERSION;
         number_accum_in    = 32'd0;
         number_bytes_in    = 3'd0;
         header_index_in    = 2'd0;
         table_size_in      = 20'd0;
         bytes_remaining_in = 24'd0;
         open_depth_in      = 6'd0;
         nodes_seen_in      = 17'd0;
         page_now_in        = 8'd0;
         root_closed_in     = 1'b0;
         error_latched_in   = 1'b0;
         text_pend_in       = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && have_ev) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_VERSION;
         number_accum_ff    <= 32'd0;
         number_bytes_ff    <= 3'd0;
         header_index_ff    <= 2'd0;
         table_size_ff      <= 20'd0;
         bytes_remaining_ff <= 24'd0;
         open_depth_ff      <= 6'd0;
         nodes_seen_ff      <= 17'd0;
         page_now_ff        <= 8'd0;
         root_closed_ff     <= 1'b0;
         error_latched_ff   <= 1'b0;
         text_pend_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         number_accum_ff    <= number_accum_in;
         number_bytes_ff    <= number_bytes_in;
         header_index_ff    <= header_index_in;
         table_size_ff      <= table_size_in;
         bytes_remaining_ff <= bytes_remaining_in;
         open_depth_ff      <= open_depth_in;
         nodes_seen_ff      <= nodes_seen_in;
         page_now_ff        <= page_now_in;
         root_closed_ff     <= root_closed_in;
         error_latched_ff   <= error_latched_in;
         text_pend_ff       <= text_pend_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      text_now_ff <= text_now_in;
      if (accept && have_ev) begin
         rsp_ff <= ev;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_ff.event_kind;
   assign rsp_value        = rsp_ff.value;
   assign rsp_header_field = rsp_ff.header_field;
   assign rsp_page_id      = rsp_ff.page_id;
   assign rsp_token        = rsp_ff.token;
   assign rsp_with_body    = rsp_ff.with_body;
   assign rsp_depth        = rsp_ff.depth;
   assign rsp_error_code   = rsp_ff.error_code;
   assign rsp_document_end = rsp_ff.document_end;

   `WSD_ASSERT(a_error_rejects, rsp_valid_ff && rsp_ff.event_kind == EV_ERROR |-> rsp_ff.document_end == DOC_REJECTED, "error event without rejected document")
   `WSD_ASSERT(a_reload_not_text, text_pend_ff |-> phase_ff != PH_TEXT, "text read during stack reload")
   `WSD_ASSERT(a_content_depth, phase_ff == PH_CONTENT |-> open_depth_ff != 6'd0, "content phase with no open element")
   `WSD_ASSERT_RST(a_reset_phase, reset |=> phase_ff == PH_VERSION && !rsp_valid_ff, "reset did not restart the document")

endmodule

// ===== design/wsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wsd_ram
   import wsd_pkg::*;
#(
   parameter int WIDTH = 20,
   parameter int DEPTH = STACK_DEPTH_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/wbxml_stream_decoder_tb.sv =====
// Self-checking testbench for the WBXML stream decoder: directed and random documents.
module wbxml_stream_decoder_tb;
   import wsd_pkg::*;

   localparam int STACK_DEPTH = STACK_DEPTH_DEF;
   localparam int IDLE_LIMIT  = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_event_kind;
   logic [31:0] rsp_value;
   logic [1:0]  rsp_header_field;
   logic [7:0]  rsp_page_id;
   logic [5:0]  rsp_token;
   logic        rsp_with_body;
   logic [4:0]  rsp_depth;
   logic [3:0]  rsp_error_code;
   logic [1:0]  rsp_document_end;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   wbxml_stream_decoder dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // limits
   logic [4:0]  lim_depth;
   logic [15:0] lim_nodes;
   logic [19:0] lim_text;
   logic [23:0] lim_opaque;
   logic [19:0] lim_table;

   // decoder state
   phase_type   ph;
   logic [31:0] num_acc;
   int unsigned num_cnt;
   int unsigned hdr_idx;
   logic [19:0] tbl_size;
   logic [23:0] remain;
   int unsigned open_lvl;
   int unsigned node_cnt;
   logic [7:0]  page;
   bit          in_error;
   logic [19:0] text_len [STACK_DEPTH];

   rsp_type     events_due[$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   bit          long_stalls = 0;
   byte unsigned doc[$];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   function automatic void restart_doc();
      ph = PH_VERSION; num_acc = '0; num_cnt = 0; hdr_idx = 0; tbl_size = '0;
      remain = '0; open_lvl = 0; node_cnt = 0; page = '0; in_error = 0;
   endfunction

   function automatic rsp_type mk(input logic [3:0] k, input logic [31:0] v);
      rsp_type e;
      e = '0;
      e.event_kind = k;
      e.value = v;
      return e;
   endfunction

   function automatic logic [3:0] open_element(input logic [7:0] b, input int unsigned d,
                                               inout rsp_type e, inout bit got);
      if (d > lim_depth || d >= STACK_DEPTH) return ERR_DEPTH;
      if (b[7] || b[5:0] < TOK_FIRST_TAG) return ERR_BAD_TAG;
      node_cnt++;
      if (node_cnt > lim_nodes) return ERR_NODES;
      e = mk(EV_TAG_OPEN, 32'd0);
      e.page_id = page; e.token = b[5:0]; e.with_body = b[6]; e.depth = d[4:0];
      got = 1;
      if (b[6]) begin
         text_len[d] = '0;
         open_lvl = d + 1;
         ph = PH_CONTENT;
      end else if (d == 0) begin
         ph = PH_DONE;
      end
      return ERR_NONE;
   endfunction

   // advance the decoder by one byte, queue any event it yields
   function automatic void decode_byte(input logic [7:0] b, input bit lst);
      rsp_type     e;
      bit          got;
      logic [3:0]  err;
      logic [31:0] v;
      int unsigned idx;
      bit          done, ovf;
      got = 0; err = ERR_NONE; e = '0;
      if (in_error) begin
         if (lst) restart_doc();
         return;
      end
      case (ph) inside
         PH_VERSION: begin
            e = mk(EV_HEADER, {24'd0, b}); got = 1;
            ph = PH_HEADNUM; hdr_idx = 1; num_acc = '0; num_cnt = 0;
         end
         PH_HEADNUM, PH_REFNUM, PH_OPQNUM: begin
            done = 0; ovf = 0;
            if (num_acc > 32'h1FF_FFFF) ovf = 1;
            else begin
               num_acc = {num_acc[24:0], b[6:0]};
               num_cnt++;
               if (!b[7]) done = 1;
               else if (num_cnt >= 5) ovf = 1;
            end
            if (ovf) err = ERR_NUMBER;
            else if (done) begin
               v = num_acc; num_acc = '0; num_cnt = 0;
               if (ph == PH_HEADNUM) begin
                  if (hdr_idx >= 3) begin
                     if (v > {12'd0, lim_table}) err = ERR_TABLE;
                     else begin
                        e = mk(EV_HEADER, v); e.header_field = HF_TABLE_LEN; got = 1;
                        tbl_size = v[19:0]; remain = v[23:0];
                        ph = (v != 0) ? PH_TABLE : PH_ROOT;
                     end
                  end else begin
                     e = mk(EV_HEADER, v); e.header_field = hdr_idx[1:0]; got = 1;
                     hdr_idx++;
                  end
               end else if (ph == PH_REFNUM) begin
                  if (v >= {12'd0, tbl_size}) err = ERR_OFFSET;
                  else begin
                     e = mk(EV_TABLE_REF, v); got = 1; ph = PH_CONTENT;
                  end
               end else begin
                  if (v > {8'd0, lim_opaque}) err = ERR_OPAQUE;
                  else begin
                     e = mk(EV_OPQ_START, v); got = 1; remain = v[23:0];
                     ph = (v != 0) ? PH_OPQDATA : PH_CONTENT;
                  end
               end
            end
         end
         PH_TABLE, PH_OPQDATA: begin
            e = mk((ph == PH_TABLE) ? EV_TABLE_BYTE : EV_OPQ_BYTE, {24'd0, b}); got = 1;
            remain = remain - 24'd1;
            if (remain == 0) ph = (ph == PH_TABLE) ? PH_ROOT : PH_CONTENT;
         end
         PH_ROOT: begin
            if (b == TOK_SWITCH_PAGE) ph = PH_PAGE;
            else err = open_element(b, 0, e, got);
         end
         PH_PAGE: begin
            page = b;
            ph = (open_lvl != 0) ? PH_CONTENT : PH_ROOT;
         end
         PH_CONTENT: begin
            if (b == TOK_SWITCH_PAGE) ph = PH_PAGE;
            else if (b == TOK_END) begin
               open_lvl = (open_lvl != 0) ? open_lvl - 1 : 0;
               e = mk(EV_TAG_END, 32'd0); e.depth = open_lvl[4:0]; got = 1;
               if (open_lvl == 0) ph = PH_DONE;
            end else if (b == TOK_STR_I) ph = PH_TEXT;
            else if (b == TOK_STR_T) ph = PH_REFNUM;
            else if (b == TOK_OPAQUE) ph = PH_OPQNUM;
            else err = open_element(b, open_lvl, e, got);
         end
         PH_TEXT: begin
            idx = (open_lvl != 0) ? open_lvl - 1 : 0;
            if (idx >= STACK_DEPTH) idx = 0;
            if (b == 0) begin
               e = mk(EV_TEXT_END, {12'd0, text_len[idx]}); got = 1; ph = PH_CONTENT;
            end else if ({12'd0, text_len[idx]} + 32'd1 > {12'd0, lim_text}) err = ERR_TEXT;
            else begin
               text_len[idx] = text_len[idx] + 20'd1;
               e = mk(EV_TEXT_BYTE, {24'd0, b}); got = 1;
            end
         end
         default: err = ERR_TRAILING;
      endcase
      if (err == ERR_NONE && lst) begin
         if (ph == PH_DONE && got) e.document_end = DOC_ACCEPTED;
         else err = ERR_TRUNC;
      end
      if (err != ERR_NONE) begin
         e = mk(EV_ERROR, 32'd0); e.error_code = err; e.document_end = DOC_REJECTED;
         got = 1; in_error = 1;
      end
      if (lst) restart_doc();
      if (got) events_due.push_back(e);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // hold valid across back-to-back requests, drop it only for a gap
   task automatic send_byte(input logic [7:0] b, input bit lst);
      int g;
      g = long_stalls ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b, lst);
   endtask

   task automatic send_doc();
      for (int i = 0; i < doc.size(); i++) send_byte(doc[i], i == doc.size() - 1);
      doc.delete();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [2:0] idx, input logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_MAX_DEPTH:      lim_depth = val[4:0];
         REG_MAX_NODES:      lim_nodes = val[15:0];
         REG_MAX_TEXT_LEN:   lim_text = val[19:0];
         REG_MAX_OPAQUE_LEN: lim_opaque = val[23:0];
         default:            lim_table = val[19:0];
      endcase
   endtask

   task automatic set_limits(input logic [4:0] d, input logic [15:0] n,
                             input logic [19:0] t, input logic [23:0] o,
                             input logic [19:0] tb);
      drain();
      write_limit(REG_MAX_DEPTH, {27'd0, d});
      write_limit(REG_MAX_NODES, {16'd0, n});
      write_limit(REG_MAX_TEXT_LEN, {12'd0, t});
      write_limit(REG_MAX_OPAQUE_LEN, {8'd0, o});
      write_limit(REG_MAX_TABLE_LEN, {12'd0, tb});
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   function automatic void push_num(input logic [31:0] v);
      byte unsigned grp[$];
      do begin
         grp.push_front({1'b0, v[6:0]});
         v = v >> 7;
      end while (v != 0);
      for (int i = 0; i < grp.size() - 1; i++) grp[i] |= 8'h80;
      foreach (grp[i]) doc.push_back(grp[i]);
   endfunction

   function automatic void push_header(input int tlen);
      doc.push_back(8'($urandom_range(0, 255)));
      push_num($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300));
      push_num($urandom_range(0, 130));
      push_num(tlen);
      for (int i = 0; i < tlen; i++) doc.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic byte unsigned rand_tag(input bit content);
      return {1'b0, content, 6'($urandom_range(5, 63))};
   endfunction

   // well-formed body with random content; depth bounded by lvl
   function automatic void push_element(input int lvl, input int tlen);
      int n;
      if ($urandom_range(0, 7) == 0) begin
         doc.push_back(TOK_SWITCH_PAGE);
         doc.push_back(8'($urandom_range(0, 255)));
      end
      if (lvl <= 0 || $urandom_range(0, 3) == 0) begin
         doc.push_back(rand_tag(0));
         return;
      end
      doc.push_back(rand_tag(1));
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 4))
            0: begin
               doc.push_back(TOK_STR_I);
               repeat ($urandom_range(0, 5)) doc.push_back(8'($urandom_range(1, 255)));
               doc.push_back(8'h00);
            end
            1: if (tlen > 0) begin
               doc.push_back(TOK_STR_T);
               push_num($urandom_range(0, tlen - 1));
            end
            2: begin
               int ol;
               ol = $urandom_range(0, 4);
               doc.push_back(TOK_OPAQUE);
               push_num(ol);
               repeat (ol) doc.push_back(8'($urandom_range(0, 255)));
            end
            3: begin
               doc.push_back(TOK_SWITCH_PAGE);
               doc.push_back(8'($urandom_range(0, 255)));
            end
            default: push_element(lvl - 1, tlen);
         endcase
      end
      doc.push_back(TOK_END);
   endfunction

   task automatic test_directed();
      // minimal doc, empty root
      doc = '{8'h03, 8'h01, 8'h6A, 8'h00, 8'h05}; send_doc();
      // all header extremes, table, page switch, content tag, all content kinds
      doc = '{8'hFF, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h02, 8'hAA, 8'h55,
              8'h00, 8'hFF, 8'h7F, 8'h03, 8'hFF, 8'h01, 8'h00, 8'h83, 8'h01,
              8'hC3, 8'h01, 8'h80, 8'h3F, 8'h01};
      send_doc();
      // bad tags: high bit, reserved global, small token
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hC5}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h01}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h44}; send_doc();
      // number overflow: five continuation bytes, then big accumulator
      doc = '{8'h00, 8'h81, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00}; send_doc();
      doc = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00}; send_doc();
      // truncated, trailing, bad offset, table too long
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h45}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h05}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'h83, 8'h00, 8'h01}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h84, 8'h80, 8'h81, 8'h00}; send_doc();
      doc = '{8'h00}; send_doc();
   endtask

   task automatic test_limits();
      // zero depth, one node, no text, no opaque, no table
      set_limits(5'd0, 16'd1, 20'd0, 24'd0, 20'd0);
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'h45, 8'h01}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'h03, 8'h41, 8'h00, 8'h01}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'hC3, 8'h01, 8'h00, 8'h01}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'hC3, 8'h00, 8'h01}; send_doc();
      set_limits(5'd1, 16'd2, 20'd2, 24'd3, 20'd1);
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'h45, 8'h45, 8'h01, 8'h01}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'h06, 8'h06, 8'h01}; send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'h03, 8'h61, 8'h62, 8'h00,
              8'h03, 8'h63, 8'h00, 8'h01};
      send_doc();
      // full depth with max limits
      set_limits(5'd31, 16'hFFFF, 20'hFFFFF, 24'hFFFFFF, 20'hFFFFF);
      doc = '{8'h00, 8'h00, 8'h00, 8'h00};
      repeat (32) doc.push_back(8'h7F);
      doc.push_back(8'h7F);
      doc.push_back(8'h01);
      send_doc();
      doc = '{8'h00, 8'h00, 8'h00, 8'h00};
      repeat (32) doc.push_back(8'h46);
      doc.push_back(8'h03); doc.push_back(8'h41); doc.push_back(8'h00);
      repeat (32) doc.push_back(8'h01);
      send_doc();
   endtask

   task automatic test_random(input int total);
      int sent;
      int tlen;
      sent = 0;
      while (sent < total) begin
         tlen = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4);
         push_header(tlen);
         push_element($urandom_range(0, 6), tlen);
         case ($urandom_range(0, 9))
            0: doc = doc[0:$urandom_range(0, doc.size() - 1)];
            1: doc.push_back(8'($urandom_range(0, 255)));
            2: doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
            default: ;
         endcase
         sent += doc.size();
         send_doc();
         if ($urandom_range(0, 40) == 0) drain();
         if ($urandom_range(0, 60) == 0)
            set_limits(5'($urandom_range(0, 31)), 16'($urandom_range(1, 40)),
                       20'($urandom_range(0, 8)), 24'($urandom_range(0, 4)),
                       20'($urandom_range(0, 4)));
         if ($urandom_range(0, 40) == 0)
            set_limits(5'd31, 16'hFFFF, 20'hFFFFF, 24'hFFFFFF, 20'hFFFFF);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (events_due.size() == 0)
               report("unexpected event", {28'd0, rsp_event_kind}, 32'd0);
            else begin
               rsp_type w;
               w = events_due.pop_front();
               if (rsp_event_kind !== w.event_kind)
                  report("kind", {28'd0, rsp_event_kind}, {28'd0, w.event_kind});
               if (rsp_value !== w.value) report("value", rsp_value, w.value);
               if (rsp_header_field !== w.header_field)
                  report("header_field", {30'd0, rsp_header_field}, {30'd0, w.header_field});
               if (rsp_page_id !== w.page_id)
                  report("page_id", {24'd0, rsp_page_id}, {24'd0, w.page_id});
               if (rsp_token !== w.token)
                  report("token", {26'd0, rsp_token}, {26'd0, w.token});
               if (rsp_with_body !== w.with_body)
                  report("with_body", {31'd0, rsp_with_body}, {31'd0, w.with_body});
               if (rsp_depth !== w.depth)
                  report("depth", {27'd0, rsp_depth}, {27'd0, w.depth});
               if (rsp_error_code !== w.error_code)
                  report("error_code", {28'd0, rsp_error_code}, {28'd0, w.error_code});
               if (rsp_document_end !== w.document_end)
                  report("document_end", {30'd0, rsp_document_end}, {30'd0, w.document_end});
            end
         end
         rsp_ready <= (long_stalls && $urandom_range(0, 99) < 30) ? 1'b0 : 1'b1;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      lim_depth = MAX_DEPTH_RST; lim_nodes = MAX_NODES_RST; lim_text = MAX_TEXT_LEN_RST;
      lim_opaque = MAX_OPAQUE_LEN_RST; lim_table = MAX_TABLE_LEN_RST;
      foreach (text_len[i]) text_len[i] = '0;
      restart_doc();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      long_stalls = 1;
      test_limits();
      long_stalls = 0;
      test_random(300);
      long_stalls = 1;
      test_random(1200);
      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/wsd_pkg.sv
design/wsd_ram.sv
design/wbxml_stream_decoder.sv
dv/wbxml_stream_decoder_tb.sv
